@@ sv/lzt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lzt_pkg
// Shared widths, register indexes, item types and helpers of the lift axis
// zero and tilt estimator.
// ----------------------------------------------------------------------------
package lzt_pkg;

	localparam int AXES     = 4;
	localparam int ANGLE_W  = 32;
	localparam int RATE_W   = 32;
	localparam int GAIN_W   = 24;
	localparam int RECIP_W  = 24;
	localparam int OUT_W    = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam int GAIN_SH  = 24;
	localparam int RECIP_SH = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_AXIS0    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_AXIS1    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_AXIS2    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_AXIS3    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RECIP_LENGTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_RECIP_WIDTH   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_ON_CAL  = 3'd6;

	localparam logic signed [GAIN_W-1:0] GAIN_RESET         = 24'sd16777;
	localparam logic [RECIP_W-1:0]       RECIP_LENGTH_RESET = 24'd81920;
	localparam logic [RECIP_W-1:0]       RECIP_WIDTH_RESET  = 24'd109227;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] angle_axis0;
		logic signed [ANGLE_W-1:0] angle_axis1;
		logic signed [ANGLE_W-1:0] angle_axis2;
		logic signed [ANGLE_W-1:0] angle_axis3;
		logic signed [RATE_W-1:0]  rate_axis0;
		logic signed [RATE_W-1:0]  rate_axis1;
		logic signed [RATE_W-1:0]  rate_axis2;
		logic signed [RATE_W-1:0]  rate_axis3;
		logic [AXES-1:0]           switch_mask;
		logic [AXES-1:0]           angle_ready_mask;
		logic                      calibrate_cmd;
	} tick_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] height_axis0;
		logic signed [OUT_W-1:0] height_axis1;
		logic signed [OUT_W-1:0] height_axis2;
		logic signed [OUT_W-1:0] height_axis3;
		logic signed [OUT_W-1:0] mean_height;
		logic signed [OUT_W-1:0] mean_height_rate;
		logic signed [OUT_W-1:0] pitch_estimate;
		logic signed [OUT_W-1:0] roll_estimate;
		logic                    pitch_valid;
		logic                    roll_valid;
		logic                    all_calibrated;
		logic [AXES-1:0]         bottom_valid_mask;
	} estimate_t;

	typedef struct packed {
		logic accept;
		logic mul;
		logic rnd;
		logic sum;
		logic tilt;
	} ctrl_t;

	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [63:0] x);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sd2147483647;
		lo = -64'sd2147483648;
		if (x > hi) begin
			return hi[OUT_W-1:0];
		end else if (x < lo) begin
			return lo[OUT_W-1:0];
		end
		return x[OUT_W-1:0];
	endfunction

endpackage
`default_nettype wire

@@ sv/lzt_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lzt_tick_if / lzt_estimate_if
// Valid/ready channels for the input items and the result items.
// ----------------------------------------------------------------------------
interface lzt_tick_if;
	logic            valid;
	logic            ready;
	lzt_pkg::tick_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface lzt_estimate_if;
	logic               valid;
	logic               ready;
	lzt_pkg::estimate_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ sv/lzt_lane.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lzt_lane
// One lift axis: startup and bottom zero latching, height and height
// velocity from the axis gain, both rounded, the height also saturated.
// ----------------------------------------------------------------------------
module lzt_lane (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  lzt_pkg::ctrl_t                        ctrl,
	input  logic signed [lzt_pkg::ANGLE_W-1:0]    angle,
	input  logic signed [lzt_pkg::RATE_W-1:0]     rate,
	input  logic                                  angle_ready,
	input  logic                                  bottom_switch,
	input  logic                                  clear_bottom,
	input  logic                                  calibrated,
	input  logic signed [lzt_pkg::GAIN_W-1:0]     gain,
	output logic signed [lzt_pkg::OUT_W-1:0]      height,
	output logic signed [lzt_pkg::OUT_W-1:0]      velocity,
	output logic                                  bottom_flag
);
	import lzt_pkg::*;

	localparam int DIFF_W  = ANGLE_W + 1;
	localparam int HPROD_W = DIFF_W + GAIN_W;
	localparam int VPROD_W = RATE_W + GAIN_W;
	localparam int HWIDE_W = HPROD_W - GAIN_SH;
	localparam logic signed [HPROD_W-1:0] HALF_H = HPROD_W'(64'sd1 <<< (GAIN_SH - 1));
	localparam logic signed [VPROD_W-1:0] HALF_V = VPROD_W'(64'sd1 <<< (GAIN_SH - 1));

	logic signed [ANGLE_W-1:0] ang_now;
	logic signed [ANGLE_W-1:0] startup_zero_q;
	logic signed [ANGLE_W-1:0] bottom_zero_q;
	logic signed [ANGLE_W-1:0] ang_s1;
	logic signed [ANGLE_W-1:0] zero_sel;
	logic                      startup_lat_q;
	logic                      bottom_lat_q;
	logic                      bottom_lat_eff;
	logic signed [RATE_W-1:0]  rate_s1;
	logic signed [DIFF_W-1:0]  diff;
	logic signed [HPROD_W-1:0] prod_h_s2;
	logic signed [HPROD_W-1:0] rnd_h;
	logic signed [VPROD_W-1:0] prod_v_s2;
	logic signed [VPROD_W-1:0] rnd_v;
	logic signed [HWIDE_W-1:0] h_wide;
	logic signed [OUT_W-1:0]   h_s3;
	logic signed [OUT_W-1:0]   v_s3;

	assign ang_now        = angle_ready ? angle : '0;
	assign bottom_lat_eff = bottom_lat_q & ~clear_bottom;
	assign zero_sel       = calibrated ? bottom_zero_q : startup_zero_q;
	assign diff           = DIFF_W'(ang_s1) - DIFF_W'(zero_sel);
	assign rnd_h          = prod_h_s2 + HALF_H;
	assign rnd_v          = prod_v_s2 + HALF_V;
	assign h_wide         = rnd_h[HPROD_W-1:GAIN_SH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			startup_zero_q <= '0;
			startup_lat_q  <= 1'b0;
			bottom_zero_q  <= '0;
			bottom_lat_q   <= 1'b0;
		end else if (ctrl.accept) begin
			if (!startup_lat_q && angle_ready) begin
				startup_zero_q <= ang_now;
				startup_lat_q  <= 1'b1;
			end
			if (bottom_switch && !bottom_lat_eff) begin
				bottom_zero_q <= ang_now;
				bottom_lat_q  <= 1'b1;
			end else begin
				bottom_lat_q <= bottom_lat_eff;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			ang_s1  <= ang_now;
			rate_s1 <= rate;
		end
		if (ctrl.mul) begin
			prod_h_s2 <= HPROD_W'(gain) * HPROD_W'(diff);
			prod_v_s2 <= VPROD_W'(gain) * VPROD_W'(rate_s1);
		end
		if (ctrl.rnd) begin
			h_s3 <= sat_out(64'(h_wide));
			v_s3 <= rnd_v[VPROD_W-1:GAIN_SH];
		end
	end

	assign height      = h_s3;
	assign velocity    = v_s3;
	assign bottom_flag = bottom_lat_q;

endmodule
`default_nettype wire

@@ sv/lzt_merge.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lzt_merge
// Combines the lane heights and velocities into the means and into the
// pitch and roll estimates.
// ----------------------------------------------------------------------------
module lzt_merge (
	input  logic                                clk,
	input  lzt_pkg::ctrl_t                      ctrl,
	input  logic signed [lzt_pkg::OUT_W-1:0]    height [lzt_pkg::AXES],
	input  logic signed [lzt_pkg::OUT_W-1:0]    velocity [lzt_pkg::AXES],
	input  logic [lzt_pkg::RECIP_W-1:0]         recip_length,
	input  logic [lzt_pkg::RECIP_W-1:0]         recip_width,
	output logic signed [lzt_pkg::OUT_W-1:0]    mean_height,
	output logic signed [lzt_pkg::OUT_W-1:0]    mean_rate,
	output logic signed [lzt_pkg::OUT_W-1:0]    pitch,
	output logic signed [lzt_pkg::OUT_W-1:0]    roll
);
	import lzt_pkg::*;

	localparam int SUM_W   = OUT_W + 2;
	localparam int TPROD_W = SUM_W + RECIP_W + 1;
	localparam int TWIDE_W = TPROD_W - RECIP_SH;
	localparam logic signed [TPROD_W-1:0] HALF_T = TPROD_W'(64'sd1 <<< (RECIP_SH - 1));

	logic signed [SUM_W-1:0]   sum_h;
	logic signed [SUM_W-1:0]   sum_v;
	logic signed [SUM_W-1:0]   diff_p;
	logic signed [SUM_W-1:0]   diff_r;
	logic signed [SUM_W-1:0]   sum_h_s4;
	logic signed [SUM_W-1:0]   sum_v_s4;
	logic signed [SUM_W-1:0]   diff_p_s4;
	logic signed [SUM_W-1:0]   diff_r_s4;
	logic signed [TPROD_W-1:0] prod_p_s5;
	logic signed [TPROD_W-1:0] prod_r_s5;
	logic signed [TPROD_W-1:0] rnd_p;
	logic signed [TPROD_W-1:0] rnd_r;
	logic signed [OUT_W-1:0]   mean_h_s5;
	logic signed [OUT_W-1:0]   mean_v_s5;
	logic signed [TWIDE_W-1:0] p_wide;
	logic signed [TWIDE_W-1:0] r_wide;

	assign sum_h  = SUM_W'(height[0]) + SUM_W'(height[1])
		+ SUM_W'(height[2]) + SUM_W'(height[3]);
	assign sum_v  = SUM_W'(velocity[0]) + SUM_W'(velocity[1])
		+ SUM_W'(velocity[2]) + SUM_W'(velocity[3]);
	// Front axes lift the nose down, hence back minus front for pitch.
	assign diff_p = (SUM_W'(height[2]) + SUM_W'(height[3]))
		- (SUM_W'(height[0]) + SUM_W'(height[1]));
	assign diff_r = (SUM_W'(height[0]) + SUM_W'(height[2]))
		- (SUM_W'(height[1]) + SUM_W'(height[3]));

	assign rnd_p  = prod_p_s5 + HALF_T;
	assign rnd_r  = prod_r_s5 + HALF_T;
	assign p_wide = rnd_p[TPROD_W-1:RECIP_SH];
	assign r_wide = rnd_r[TPROD_W-1:RECIP_SH];

	always_ff @(posedge clk) begin
		if (ctrl.sum) begin
			sum_h_s4  <= sum_h;
			sum_v_s4  <= sum_v;
			diff_p_s4 <= diff_p;
			diff_r_s4 <= diff_r;
		end
		if (ctrl.tilt) begin
			prod_p_s5 <= TPROD_W'(diff_p_s4) * TPROD_W'(recip_length);
			prod_r_s5 <= TPROD_W'(diff_r_s4) * TPROD_W'(recip_width);
			mean_h_s5 <= sum_h_s4[SUM_W-1:2];
			mean_v_s5 <= sum_v_s4[SUM_W-1:2];
		end
	end

	assign mean_height = mean_h_s5;
	assign mean_rate   = mean_v_s5;
	assign pitch       = (recip_length != '0) ? sat_out(64'(p_wide)) : '0;
	assign roll        = (recip_width != '0) ? sat_out(64'(r_wide)) : '0;

endmodule
`default_nettype wire

@@ sv/lift_axis_zero_and_tilt_estimator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lift_axis_zero_and_tilt_estimator
// Takes one item per control tick with four lift-motor angles and rates and
// returns one result item with the four axis heights, their mean, the mean
// height velocity and the pitch and roll estimates. Each axis runs in its own
// lane with its own pair of multipliers; a merge stage forms the sums and the
// tilt products. An item passes from acceptance through the lane multiply, the
// lane rounding, the merge sums, the tilt multiply and the final rounding step
// until its result is loaded into the output register. The next item is taken
// only in the idle state, after the previous one has left the last step. A new
// item is accepted while the previous result still waits in the output
// register; only the last step waits for that register to empty.
// Configuration writes take effect at once and must be made while no item is
// in flight.
// ----------------------------------------------------------------------------
module lift_axis_zero_and_tilt_estimator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lzt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lzt_pkg::CFG_DATA_W-1:0]    cfg_data,
	lzt_tick_if.sink                          tick,
	lzt_estimate_if.source                    estimate
);
	import lzt_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL  = 6'b000010,
		ST_RND  = 6'b000100,
		ST_SUM  = 6'b001000,
		ST_TILT = 6'b010000,
		ST_OUT  = 6'b100000
	} seq_state_t;

	seq_state_t               state_q;
	seq_state_t               state_d;
	ctrl_t                    ctrl;
	logic signed [GAIN_W-1:0] gain_q [AXES];
	logic [RECIP_W-1:0]       recip_length_q;
	logic [RECIP_W-1:0]       recip_width_q;
	logic                     clear_cal_q;
	logic                     prev_cal_q;
	logic                     clear_bottom;
	logic                     calibrated;
	logic                     out_load;
	logic                     out_valid_q;
	estimate_t                out_q;

	logic signed [ANGLE_W-1:0] lane_angle    [AXES];
	logic signed [RATE_W-1:0]  lane_rate     [AXES];
	logic signed [OUT_W-1:0]   lane_height   [AXES];
	logic signed [OUT_W-1:0]   lane_velocity [AXES];
	logic [AXES-1:0]           bottom_flags;
	logic signed [OUT_W-1:0]   mean_height;
	logic signed [OUT_W-1:0]   mean_rate;
	logic signed [OUT_W-1:0]   pitch;
	logic signed [OUT_W-1:0]   roll;

	assign tick.ready     = (state_q == ST_IDLE);
	assign ctrl.accept    = tick.valid & tick.ready;
	assign ctrl.mul       = (state_q == ST_MUL);
	assign ctrl.rnd       = (state_q == ST_RND);
	assign ctrl.sum       = (state_q == ST_SUM);
	assign ctrl.tilt      = (state_q == ST_TILT);
	assign out_load       = (state_q == ST_OUT) && (!out_valid_q || estimate.ready);
	assign clear_bottom   = tick.data.calibrate_cmd & ~prev_cal_q & clear_cal_q;
	assign calibrated     = &bottom_flags;

	assign lane_angle[0] = tick.data.angle_axis0;
	assign lane_angle[1] = tick.data.angle_axis1;
	assign lane_angle[2] = tick.data.angle_axis2;
	assign lane_angle[3] = tick.data.angle_axis3;
	assign lane_rate[0]  = tick.data.rate_axis0;
	assign lane_rate[1]  = tick.data.rate_axis1;
	assign lane_rate[2]  = tick.data.rate_axis2;
	assign lane_rate[3]  = tick.data.rate_axis3;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (ctrl.accept) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL:  state_d = ST_RND;
			ST_RND:  state_d = ST_SUM;
			ST_SUM:  state_d = ST_TILT;
			ST_TILT: state_d = ST_OUT;
			ST_OUT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_cal_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.accept) begin
				prev_cal_q <= tick.data.calibrate_cmd;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (estimate.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXES; i++) begin
				gain_q[i] <= GAIN_RESET;
			end
			recip_length_q <= RECIP_LENGTH_RESET;
			recip_width_q  <= RECIP_WIDTH_RESET;
			clear_cal_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GAIN_AXIS0:   gain_q[0]      <= $signed(cfg_data[GAIN_W-1:0]);
				CFG_GAIN_AXIS1:   gain_q[1]      <= $signed(cfg_data[GAIN_W-1:0]);
				CFG_GAIN_AXIS2:   gain_q[2]      <= $signed(cfg_data[GAIN_W-1:0]);
				CFG_GAIN_AXIS3:   gain_q[3]      <= $signed(cfg_data[GAIN_W-1:0]);
				CFG_RECIP_LENGTH: recip_length_q <= cfg_data[RECIP_W-1:0];
				CFG_RECIP_WIDTH:  recip_width_q  <= cfg_data[RECIP_W-1:0];
				CFG_CLEAR_ON_CAL: clear_cal_q    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	for (genvar g = 0; g < AXES; g++) begin : g_lane
		lzt_lane u_lane (
			.clk           (clk),
			.arst_n        (arst_n),
			.ctrl          (ctrl),
			.angle         (lane_angle[g]),
			.rate          (lane_rate[g]),
			.angle_ready   (tick.data.angle_ready_mask[g]),
			.bottom_switch (tick.data.switch_mask[g]),
			.clear_bottom  (clear_bottom),
			.calibrated    (calibrated),
			.gain          (gain_q[g]),
			.height        (lane_height[g]),
			.velocity      (lane_velocity[g]),
			.bottom_flag   (bottom_flags[g])
		);
	end

	lzt_merge u_merge (
		.clk          (clk),
		.ctrl         (ctrl),
		.height       (lane_height),
		.velocity     (lane_velocity),
		.recip_length (recip_length_q),
		.recip_width  (recip_width_q),
		.mean_height  (mean_height),
		.mean_rate    (mean_rate),
		.pitch        (pitch),
		.roll         (roll)
	);

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.height_axis0      <= lane_height[0];
			out_q.height_axis1      <= lane_height[1];
			out_q.height_axis2      <= lane_height[2];
			out_q.height_axis3      <= lane_height[3];
			out_q.mean_height       <= mean_height;
			out_q.mean_height_rate  <= mean_rate;
			out_q.pitch_estimate    <= pitch;
			out_q.roll_estimate     <= roll;
			out_q.pitch_valid       <= (recip_length_q != '0);
			out_q.roll_valid        <= (recip_width_q != '0);
			out_q.all_calibrated    <= calibrated;
			out_q.bottom_valid_mask <= bottom_flags;
		end
	end

	assign estimate.valid = out_valid_q;
	assign estimate.data  = out_q;

endmodule
`default_nettype wire

@@ dv/lift_axis_zero_and_tilt_estimator_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lift_axis_zero_and_tilt_estimator_test
// Self-checking testbench of the lift axis zero and tilt estimator. A local
// model of the zero latching, height scaling, averaging and tilt arithmetic
// predicts one result for every accepted item, and a monitor compares each
// returned result with the oldest prediction. Directed items cover the
// extremes and the calibration cases; random items under several register
// settings follow, with random idling on both channels and one long output
// stall.
// ----------------------------------------------------------------------------
module lift_axis_zero_and_tilt_estimator_test;
	import lzt_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASE_ITEMS = 290;
	localparam int REPORT_LIMIT = 200;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	lzt_tick_if tick_ch();
	lzt_estimate_if est_ch();

	lift_axis_zero_and_tilt_estimator dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.tick(tick_ch),
		.estimate(est_ch)
	);

	// Local copy of the block's registers and zero-tracking state.
	logic signed [GAIN_W-1:0] gain [AXES];
	logic [RECIP_W-1:0] recip_len;
	logic [RECIP_W-1:0] recip_wid;
	logic clear_cal;
	longint startup_zero [AXES];
	logic [AXES-1:0] startup_latched;
	longint bottom_zero [AXES];
	logic [AXES-1:0] bottom_latched;
	logic prev_cal;

	estimate_t pending_estimates[$];
	int mismatch_count;
	int cycle_count;
	int hold_count;
	bit idle_on;
	logic cal_level;
	logic [31:0] centre [AXES];

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	function automatic longint clamp32(input longint x);
		if (x > 64'sd2147483647) begin
			return 64'sd2147483647;
		end
		if (x < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return x;
	endfunction

	function automatic longint round_q24(input longint x);
		return (x + 64'sd8388608) >>> 24;
	endfunction

	function automatic int pick_gap();
		int r;
		if (!idle_on) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic void reset_model();
		int i;
		for (i = 0; i < AXES; i++) begin
			gain[i] = GAIN_RESET;
			startup_zero[i] = 0;
			bottom_zero[i] = 0;
		end
		recip_len = RECIP_LENGTH_RESET;
		recip_wid = RECIP_WIDTH_RESET;
		clear_cal = 1'b0;
		startup_latched = '0;
		bottom_latched = '0;
		prev_cal = 1'b0;
	endfunction

	function automatic estimate_t predict_estimate(input tick_t t);
		logic signed [31:0] angle_in [AXES];
		logic signed [31:0] rate_in [AXES];
		longint angle [AXES];
		longint height [AXES];
		longint speed [AXES];
		longint zero_ref;
		longint sum_h;
		longint sum_v;
		longint diff;
		logic calibrated;
		estimate_t e;
		int i;
		angle_in[0] = t.angle_axis0;
		angle_in[1] = t.angle_axis1;
		angle_in[2] = t.angle_axis2;
		angle_in[3] = t.angle_axis3;
		rate_in[0] = t.rate_axis0;
		rate_in[1] = t.rate_axis1;
		rate_in[2] = t.rate_axis2;
		rate_in[3] = t.rate_axis3;
		if (t.calibrate_cmd && !prev_cal && clear_cal) begin
			bottom_latched = '0;
		end
		prev_cal = t.calibrate_cmd;
		for (i = 0; i < AXES; i++) begin
			angle[i] = t.angle_ready_mask[i] ? longint'(angle_in[i]) : 64'sd0;
			if (!startup_latched[i] && t.angle_ready_mask[i]) begin
				startup_zero[i] = angle[i];
				startup_latched[i] = 1'b1;
			end
			if (t.switch_mask[i] && !bottom_latched[i]) begin
				bottom_zero[i] = angle[i];
				bottom_latched[i] = 1'b1;
			end
		end
		calibrated = &bottom_latched;
		sum_h = 0;
		sum_v = 0;
		for (i = 0; i < AXES; i++) begin
			zero_ref = calibrated ? bottom_zero[i] : startup_zero[i];
			height[i] = clamp32(round_q24(longint'(gain[i]) * (angle[i] - zero_ref)));
			speed[i] = clamp32(round_q24(longint'(gain[i]) * longint'(rate_in[i])));
			sum_h += height[i];
			sum_v += speed[i];
		end
		e.height_axis0 = 32'(height[0]);
		e.height_axis1 = 32'(height[1]);
		e.height_axis2 = 32'(height[2]);
		e.height_axis3 = 32'(height[3]);
		e.mean_height = 32'(sum_h >>> 2);
		e.mean_height_rate = 32'(sum_v >>> 2);
		diff = (height[2] + height[3]) - (height[0] + height[1]);
		e.pitch_estimate = (recip_len != '0) ?
			32'(clamp32((diff * longint'({40'd0, recip_len}) + 64'sd32768) >>> 16)) : '0;
		diff = (height[0] + height[2]) - (height[1] + height[3]);
		e.roll_estimate = (recip_wid != '0) ?
			32'(clamp32((diff * longint'({40'd0, recip_wid}) + 64'sd32768) >>> 16)) : '0;
		e.pitch_valid = (recip_len != '0);
		e.roll_valid = (recip_wid != '0);
		e.all_calibrated = calibrated;
		e.bottom_valid_mask = bottom_latched;
		return e;
	endfunction

	function automatic tick_t make_tick(input logic [31:0] a0, input logic [31:0] a1,
			input logic [31:0] a2, input logic [31:0] a3, input logic [31:0] r,
			input logic [3:0] sw, input logic [3:0] rdy, input logic cal);
		tick_t t;
		t.angle_axis0 = a0;
		t.angle_axis1 = a1;
		t.angle_axis2 = a2;
		t.angle_axis3 = a3;
		t.rate_axis0 = r;
		t.rate_axis1 = ~r;
		t.rate_axis2 = r;
		t.rate_axis3 = ~r;
		t.switch_mask = sw;
		t.angle_ready_mask = rdy;
		t.calibrate_cmd = cal;
		return t;
	endfunction

	function automatic logic [31:0] rand_word(input logic [31:0] mid);
		case ($urandom_range(0, 9))
			0, 1: begin
				return $urandom;
			end
			2: begin
				case ($urandom_range(0, 3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			default: begin
				return mid + $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
			end
		endcase
	endfunction

	function automatic tick_t random_tick();
		tick_t t;
		if ($urandom_range(0, 99) < 8) begin
			cal_level = ~cal_level;
		end
		t.angle_axis0 = rand_word(centre[0]);
		t.angle_axis1 = rand_word(centre[1]);
		t.angle_axis2 = rand_word(centre[2]);
		t.angle_axis3 = rand_word(centre[3]);
		t.rate_axis0 = rand_word(32'd0);
		t.rate_axis1 = rand_word(32'd0);
		t.rate_axis2 = rand_word(32'd0);
		t.rate_axis3 = rand_word(32'd0);
		t.angle_ready_mask = ($urandom_range(0, 99) < 85) ? 4'hF : 4'($urandom_range(0, 15));
		t.switch_mask = ($urandom_range(0, 99) < 88) ? 4'h0 : 4'($urandom_range(1, 15));
		t.calibrate_cmd = cal_level;
		return t;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			CFG_GAIN_AXIS0, CFG_GAIN_AXIS1, CFG_GAIN_AXIS2, CFG_GAIN_AXIS3: begin
				gain[idx] = value;
			end
			CFG_RECIP_LENGTH: begin
				recip_len = value;
			end
			CFG_RECIP_WIDTH: begin
				recip_wid = value;
			end
			CFG_CLEAR_ON_CAL: begin
				clear_cal = value[0];
			end
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_tick(input tick_t t);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			tick_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		tick_ch.valid <= 1'b1;
		tick_ch.data <= t;
		do begin
			@(posedge clk);
		end while (!tick_ch.ready);
		pending_estimates.push_back(predict_estimate(t));
	endtask

	task automatic drain_estimates();
		@(negedge clk);
		tick_ch.valid <= 1'b0;
		while (pending_estimates.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Output side: random stalls, plus a long hold-off when one is requested.
	initial begin
		bit ready_next;
		int stall_left;
		stall_left = 0;
		est_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_count > 0) begin
				ready_next = 1'b0;
				hold_count--;
			end else if (stall_left > 0) begin
				ready_next = 1'b0;
				stall_left--;
			end else begin
				ready_next = 1'b1;
				if ($urandom_range(0, 3) == 0) begin
					stall_left = pick_gap();
				end
			end
			est_ch.ready <= ready_next;
		end
	end

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_LIMIT) begin
				$display("%0t: %s expected %08h actual %08h", $time, name, want, got);
			end
		end
	endtask

	initial begin
		estimate_t want;
		estimate_t got;
		forever begin
			@(posedge clk);
			if (arst_n && est_ch.valid === 1'b1 && est_ch.ready === 1'b1) begin
				got = est_ch.data;
				if (pending_estimates.size() == 0) begin
					mismatch_count++;
					$display("%0t: result with no item outstanding, actual %h", $time, got);
				end else begin
					want = pending_estimates.pop_front();
					check_field("height_axis0", want.height_axis0, got.height_axis0);
					check_field("height_axis1", want.height_axis1, got.height_axis1);
					check_field("height_axis2", want.height_axis2, got.height_axis2);
					check_field("height_axis3", want.height_axis3, got.height_axis3);
					check_field("mean_height", want.mean_height, got.mean_height);
					check_field("mean_height_rate", want.mean_height_rate, got.mean_height_rate);
					check_field("pitch_estimate", want.pitch_estimate, got.pitch_estimate);
					check_field("roll_estimate", want.roll_estimate, got.roll_estimate);
					check_field("pitch_valid", 32'(want.pitch_valid), 32'(got.pitch_valid));
					check_field("roll_valid", 32'(want.roll_valid), 32'(got.roll_valid));
					check_field("all_calibrated", 32'(want.all_calibrated),
						32'(got.all_calibrated));
					check_field("bottom_valid_mask", 32'(want.bottom_valid_mask),
						32'(got.bottom_valid_mask));
				end
			end
		end
	end

	task automatic test_startup_zero();
		idle_on = 1'b0;
		send_tick(make_tick(32'h1234_5678, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
			32'h0, 4'h0, 4'h0, 1'b0));
		send_tick(make_tick(32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
			32'h7FFF_FFFF, 4'h0, 4'b0101, 1'b0));
		send_tick(make_tick(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
			32'h8000_0000, 4'h0, 4'hF, 1'b0));
		send_tick(make_tick(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h0000_0001, 4'h0, 4'hF, 1'b0));
		drain_estimates();
	endtask

	task automatic test_gain_extremes();
		idle_on = 1'b1;
		write_reg(CFG_GAIN_AXIS0, 24'h7F_FFFF);
		write_reg(CFG_GAIN_AXIS1, 24'h80_0000);
		write_reg(CFG_GAIN_AXIS2, 24'h00_0000);
		write_reg(CFG_GAIN_AXIS3, 24'hFF_FFFF);
		write_reg(CFG_RECIP_LENGTH, 24'hFF_FFFF);
		write_reg(CFG_RECIP_WIDTH, 24'h00_0000);
		send_tick(make_tick(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 4'h0, 4'hF, 1'b0));
		send_tick(make_tick(32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678, 32'h8000_0000,
			32'h8000_0000, 4'h0, 4'hF, 1'b0));
		drain_estimates();
		write_reg(CFG_GAIN_AXIS0, 24'h80_0000);
		write_reg(CFG_GAIN_AXIS1, 24'h7F_FFFF);
		write_reg(CFG_GAIN_AXIS2, 24'hFF_FFFF);
		write_reg(CFG_GAIN_AXIS3, 24'h00_0000);
		write_reg(CFG_RECIP_LENGTH, 24'h00_0000);
		write_reg(CFG_RECIP_WIDTH, 24'hFF_FFFF);
		send_tick(make_tick(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 4'h0, 4'hF, 1'b0));
		send_tick(make_tick(32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678, 32'h8000_0000,
			32'h8000_0000, 4'h0, 4'hF, 1'b0));
		drain_estimates();
	endtask

	task automatic test_bottom_zero();
		write_reg(CFG_GAIN_AXIS0, 24'd16777);
		write_reg(CFG_GAIN_AXIS1, -24'sd16777);
		write_reg(CFG_GAIN_AXIS2, 24'd1048576);
		write_reg(CFG_GAIN_AXIS3, -24'sd1048576);
		write_reg(CFG_RECIP_LENGTH, RECIP_LENGTH_RESET);
		write_reg(CFG_RECIP_WIDTH, 24'd1);
		send_tick(make_tick(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000,
			32'h100, 4'b0001, 4'hF, 1'b0));
		send_tick(make_tick(32'h0005_0000, 32'hFFFA_0000, 32'h0007_0000, 32'h0008_0000,
			32'h200, 4'b0011, 4'b1101, 1'b0));
		send_tick(make_tick(32'h0009_0000, 32'h000A_0000, 32'hFFF5_0000, 32'h000C_0000,
			32'h300, 4'b0100, 4'hF, 1'b0));
		send_tick(make_tick(32'h000D_0000, 32'h000E_0000, 32'h000F_0000, 32'h0010_0000,
			32'h400, 4'b1000, 4'b0111, 1'b0));
		send_tick(make_tick(32'h0020_0000, 32'hFFE0_0000, 32'h0030_0000, 32'h0040_0000,
			32'hFFFF_FC00, 4'hF, 4'hF, 1'b0));
		drain_estimates();
	endtask

	task automatic test_calibrate_clear();
		write_reg(CFG_CLEAR_ON_CAL, 24'd1);
		send_tick(make_tick(32'h0011_0000, 32'h0012_0000, 32'h0013_0000, 32'h0014_0000,
			32'h0, 4'h0, 4'hF, 1'b1));
		send_tick(make_tick(32'h0021_0000, 32'h0022_0000, 32'h0023_0000, 32'h0024_0000,
			32'h0, 4'hF, 4'hF, 1'b1));
		send_tick(make_tick(32'h0031_0000, 32'h0032_0000, 32'h0033_0000, 32'h0034_0000,
			32'h0, 4'h0, 4'hF, 1'b0));
		send_tick(make_tick(32'h0041_0000, 32'h0042_0000, 32'h0043_0000, 32'h0044_0000,
			32'h0, 4'b0011, 4'hF, 1'b1));
		send_tick(make_tick(32'h0051_0000, 32'h0052_0000, 32'h0053_0000, 32'h0054_0000,
			32'h0, 4'b1100, 4'hF, 1'b0));
		drain_estimates();
		write_reg(CFG_CLEAR_ON_CAL, 24'd0);
		write_reg(CFG_UNUSED_INDEX, 24'hFF_FFFF);
		send_tick(make_tick(32'h0061_0000, 32'h0062_0000, 32'h0063_0000, 32'h0064_0000,
			32'h0, 4'h0, 4'hF, 1'b1));
		send_tick(make_tick(32'h0071_0000, 32'h0072_0000, 32'h0073_0000, 32'h0074_0000,
			32'h0, 4'hF, 4'hF, 1'b0));
		drain_estimates();
	endtask

	task automatic test_output_stall();
		int n;
		idle_on = 1'b0;
		hold_count = 400;
		for (n = 0; n < 30; n++) begin
			send_tick(random_tick());
		end
		drain_estimates();
		idle_on = 1'b1;
	endtask

	task automatic program_phase(input int kind);
		logic [GAIN_W-1:0] g;
		logic [RECIP_W-1:0] rl;
		logic [RECIP_W-1:0] rw;
		int i;
		for (i = 0; i < AXES; i++) begin
			case (kind)
				0: begin
					g = 24'd16777 + 24'($urandom_range(0, 2000)) - 24'd1000;
					if ($urandom_range(0, 1) == 1) begin
						g = -g;
					end
				end
				1: g = (i % 2 == 0) ? 24'h7F_FFFF : 24'h80_0000;
				default: g = 24'($urandom);
			endcase
			write_reg(CFG_GAIN_AXIS0 + 3'(i), g);
			centre[i] = $urandom;
		end
		case (kind)
			0: begin
				rl = RECIP_LENGTH_RESET;
				rw = RECIP_WIDTH_RESET;
			end
			1: begin
				rl = 24'hFF_FFFF;
				rw = 24'hFF_FFFF;
			end
			2: begin
				rl = 24'h00_0000;
				rw = 24'h00_0001;
			end
			default: begin
				rl = ($urandom_range(0, 4) == 0) ? 24'h0 : 24'($urandom);
				rw = ($urandom_range(0, 4) == 0) ? 24'h0 : 24'($urandom);
			end
		endcase
		write_reg(CFG_RECIP_LENGTH, rl);
		write_reg(CFG_RECIP_WIDTH, rw);
		write_reg(CFG_CLEAR_ON_CAL, (kind == 2) ? 24'd0 : 24'($urandom_range(0, 1)) | 24'(kind == 1));
	endtask

	task automatic test_random_phases();
		int kind;
		int n;
		for (kind = 0; kind < 5; kind++) begin
			idle_on = (kind != 0);
			program_phase(kind);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				send_tick(random_tick());
			end
			drain_estimates();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		tick_ch.valid = 1'b0;
		tick_ch.data = '0;
		mismatch_count = 0;
		hold_count = 0;
		idle_on = 1'b0;
		cal_level = 1'b0;
		reset_model();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_startup_zero();
		test_gain_extremes();
		test_bottom_zero();
		test_calibrate_clear();
		test_output_stall();
		test_random_phases();

		repeat (20) @(posedge clk);
		if (pending_estimates.size() != 0) begin
			mismatch_count++;
		end
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

@@ sim.f @@
sv/lzt_pkg.sv
sv/lzt_if.sv
sv/lzt_lane.sv
sv/lzt_merge.sv
sv/lift_axis_zero_and_tilt_estimator.sv
dv/lift_axis_zero_and_tilt_estimator_test.sv
